FILE: sv/cld_pkg.sv
// Package with shared types, constants and lookup tables for the caption decoder.
package cld_pkg;

	typedef enum logic [1:0] {
		SET_ALNUM   = 2'd0,
		SET_LATIN   = 2'd1,
		SET_SPECIAL = 2'd2,
		SET_DRCS    = 2'd3
	} gset_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_ESC    = 4'd1,
		PH_DESIG  = 4'd2,
		PH_FINAL  = 4'd3,
		PH_ESC24  = 4'd4,
		PH_ESC24X = 4'd5,
		PH_FLC    = 4'd6,
		PH_TIM1   = 4'd7,
		PH_TIM2   = 4'd8
	} phase_t;

	localparam logic [1:0] REG_GL    = 2'd0;
	localparam logic [1:0] REG_GR    = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	// One front-end transaction: up to three code units produced by one byte.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [15:0] u0;
		logic [15:0] u1;
		logic [15:0] u2;
	} run_t;

	function automatic logic [15:0] latin_lut(input logic [6:0] i);
		logic [15:0] r;
		begin
			case (i)
				7'd4:  r = 16'h20AC;
				7'd6:  r = 16'h0160;
				7'd8:  r = 16'h0161;
				7'd20: r = 16'h017D;
				7'd24: r = 16'h017E;
				7'd28: r = 16'h0152;
				7'd29: r = 16'h0153;
				7'd30: r = 16'h0178;
				default: begin
					if (i == 7'd0 || i >= 7'd95)
						r = 16'h0000;
					else
						r = 16'h00A0 + {9'd0, i};
				end
			endcase
			latin_lut = r;
		end
	endfunction

	function automatic logic [15:0] special_lut(input logic [7:0] b);
		logic [15:0] r;
		begin
			case (b)
				8'h21: r = 16'h266A;
				8'h30: r = 16'h00A4;
				8'h31: r = 16'h00A6;
				8'h32: r = 16'h00A8;
				8'h33: r = 16'h00B4;
				8'h34: r = 16'h00B8;
				8'h35: r = 16'h00BC;
				8'h36: r = 16'h00BD;
				8'h37: r = 16'h00BE;
				8'h40: r = 16'h2026;
				8'h41: r = 16'h2588;
				8'h42: r = 16'h2018;
				8'h43: r = 16'h2019;
				8'h44: r = 16'h201C;
				8'h45: r = 16'h201D;
				8'h46: r = 16'h2022;
				8'h47: r = 16'h2122;
				8'h48: r = 16'h215B;
				8'h49: r = 16'h215C;
				8'h4A: r = 16'h215D;
				8'h4B: r = 16'h215E;
				default: r = 16'h0000;
			endcase
			special_lut = r;
		end
	endfunction

	function automatic gset_t final_to_set(input logic [7:0] f);
		begin
			if (f == 8'h4A)
				final_to_set = SET_ALNUM;
			else if (f == 8'h4C)
				final_to_set = SET_SPECIAL;
			else
				final_to_set = SET_LATIN;
		end
	endfunction

endpackage

FILE: sv/cld_front.sv
// Front end: parses escape sequences, tracks G-set state and maps one byte to a run.
module cld_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  logic             block_end,
	input  logic             in_fire,
	input  logic [1:0]       init_gl,
	input  logic [1:0]       init_gr,
	input  logic [15:0]      limit,
	output cld_pkg::run_t    run
);
	import cld_pkg::*;

	gset_t       dsets_q [4];
	gset_t       gl_q, gr_q, saved_gl_q;
	logic        ss_q, lim_q;
	phase_t      ph_q;
	logic [7:0]  held_q;
	logic [15:0] cnt_q;

	gset_t       ds [4];
	gset_t       gl, gr, sgl;
	logic        ss;
	phase_t      ph;
	logic [7:0]  held;
	logic [15:0] cnt;
	logic [1:0]  n;
	logic [15:0] u [3];

	// Decode of one byte in the idle phase; the escape path may run it up to twice.
	always_comb begin
		logic [7:0]  b [2];
		logic        bv [2];
		logic [15:0] v;
		logic        e;
		logic [15:0] ua [3];
		logic [1:0]  na;
		logic [1:0]  j;
		ds = dsets_q;
		gl = gl_q;
		gr = gr_q;
		sgl = saved_gl_q;
		ss = ss_q;
		ph = ph_q;
		held = held_q;
		cnt = cnt_q;
		ua[0] = 16'h0;
		ua[1] = 16'h0;
		ua[2] = 16'h0;
		na = 2'd0;
		b[0] = data_byte;
		b[1] = 8'h20;
		bv[0] = 1'b0;
		bv[1] = 1'b0;
		v = 16'h0;
		e = 1'b0;
		j = 2'd0;
		if (!lim_q) begin
			ph = PH_IDLE;
			unique case (ph_q)
				PH_ESC: begin
					if (data_byte == 8'h6E)
						gl = ds[2];
					else if (data_byte == 8'h6F)
						gl = ds[3];
					else if (data_byte == 8'h7E)
						gr = ds[1];
					else if (data_byte == 8'h7D)
						gr = ds[2];
					else if (data_byte == 8'h7C)
						gr = ds[3];
					else if (data_byte >= 8'h28 && data_byte <= 8'h2B) begin
						held = data_byte;
						ph = PH_DESIG;
					end else if (data_byte == 8'h24)
						ph = PH_ESC24;
					else
						bv[0] = 1'b1;
				end
				PH_DESIG: begin
					if (data_byte == 8'h20)
						ph = PH_FINAL;
					else
						ds[held_q[1:0]] = final_to_set(data_byte);
				end
				PH_FINAL: ds[held_q[1:0]] = final_to_set(data_byte);
				PH_ESC24: begin
					held = data_byte;
					ph = PH_ESC24X;
				end
				PH_ESC24X: begin
					if (data_byte == 8'h20) begin
						if (held_q >= 8'h28 && held_q <= 8'h2B)
							ph = PH_FINAL;
						else begin
							b[0] = held_q;
							bv[0] = 1'b1;
							bv[1] = 1'b1;
						end
					end else if (held_q >= 8'h29 && held_q <= 8'h2B)
						ds[held_q[1:0]] = final_to_set(data_byte);
					else begin
						ds[0] = final_to_set(held_q);
						bv[0] = 1'b1;
					end
				end
				PH_FLC: ph = PH_IDLE;
				PH_TIM1: ph = PH_TIM2;
				PH_TIM2: ph = PH_IDLE;
				default: bv[0] = 1'b1;
			endcase
			// The second pass sees a space; after ESC it prints, as an operand it is consumed.
			for (int k = 0; k < 2; k++) begin
				if (k == 1 && bv[1]) begin
					if (ph == PH_ESC)
						ph = PH_IDLE;
					else if (ph == PH_FLC) begin
						ph = PH_IDLE;
						bv[1] = 1'b0;
					end else if (ph == PH_TIM1) begin
						ph = PH_TIM2;
						bv[1] = 1'b0;
					end
				end
				if (bv[k] && ph == PH_IDLE) begin
					v = 16'h0;
					e = 1'b0;
					j = 2'd0;
					if (b[k] < 8'h20) begin
						case (b[k])
							8'h1B: ph = PH_ESC;
							8'h0F: gl = ds[0];
							8'h0E: gl = ds[1];
							8'h19, 8'h1D: begin
								sgl = gl;
								gl = (b[k] == 8'h19) ? ds[2] : ds[3];
								ss = 1'b1;
							end
							8'h0D: begin
								v = 16'h000D;
								e = 1'b1;
								j = 2'd1;
							end
							default: ;
						endcase
					end else if (b[k] < 8'h80) begin
						if (b[k] == 8'h20 || b[k] == 8'h7F)
							v = {8'h0, b[k]};
						else if (gl == SET_ALNUM)
							v = {8'h0, b[k]};
						else if (gl == SET_LATIN)
							v = latin_lut(7'(b[k] - 8'h20));
						else if (gl == SET_SPECIAL)
							v = special_lut(b[k]);
						e = (v != 16'h0) || b[k] == 8'h20 || b[k] == 8'h7F
							|| (gl == SET_ALNUM);
						if (ss) begin
							gl = sgl;
							ss = 1'b0;
						end
					end else if (b[k] < 8'hA0) begin
						if (b[k] == 8'h91)
							ph = PH_FLC;
						else if (b[k] == 8'h9D)
							ph = PH_TIM1;
					end else begin
						if (gr == SET_ALNUM) begin
							v = {8'h0, b[k] - 8'h80};
							e = 1'b1;
						end else if (gr == SET_LATIN) begin
							v = latin_lut(7'(b[k] - 8'hA0));
							e = (v != 16'h0);
						end
					end
					if (e && cnt < limit && na != 2'd3) begin
						ua[na] = v;
						na = na + 2'd1;
						cnt = cnt + 16'd1;
					end
					if (j != 2'd0 && cnt < limit && na != 2'd3) begin
						ua[na] = 16'h000A;
						na = na + 2'd1;
						cnt = cnt + 16'd1;
					end
				end
			end
		end
		u = ua;
		n = na;
	end

	assign run.cnt = n;
	assign run.u0 = u[0];
	assign run.u1 = u[1];
	assign run.u2 = u[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsets_q[0] <= SET_ALNUM;
			dsets_q[1] <= SET_ALNUM;
			dsets_q[2] <= SET_LATIN;
			dsets_q[3] <= SET_SPECIAL;
			gl_q <= SET_ALNUM;
			gr_q <= SET_LATIN;
			saved_gl_q <= SET_ALNUM;
			ss_q <= 1'b0;
			lim_q <= 1'b0;
			ph_q <= PH_IDLE;
			held_q <= 8'h0;
			cnt_q <= 16'h0;
		end else if (in_fire) begin
			if (block_end) begin
				dsets_q[0] <= SET_ALNUM;
				dsets_q[1] <= SET_ALNUM;
				dsets_q[2] <= SET_LATIN;
				dsets_q[3] <= SET_SPECIAL;
				gl_q <= gset_t'(init_gl);
				gr_q <= gset_t'(init_gr);
				saved_gl_q <= SET_ALNUM;
				ss_q <= 1'b0;
				lim_q <= 1'b0;
				ph_q <= PH_IDLE;
				held_q <= 8'h0;
				cnt_q <= 16'h0;
			end else begin
				dsets_q <= ds;
				gl_q <= gl;
				gr_q <= gr;
				saved_gl_q <= sgl;
				ss_q <= ss;
				ph_q <= ph;
				held_q <= held;
				cnt_q <= cnt;
				lim_q <= lim_q || (cnt >= limit);
			end
		end
	end

endmodule

FILE: sv/cld_queue.sv
// Short queue of decoded runs between the front end and the output sequencer.
module cld_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cld_pkg::run_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output cld_pkg::run_t rdata
);
	import cld_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	run_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW + 1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop && !empty)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(push && !full) - (AW + 1)'(pop && !empty);
		end
	end

endmodule

FILE: sv/cld_back.sv
// Back end: sends the code units of each queued run one transaction at a time.
module cld_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  cld_pkg::run_t run,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,
	output logic          m_axis_tlast
);
	import cld_pkg::*;

	logic [1:0] idx_q;

	assign m_axis_tvalid = !empty && run.cnt != 2'd0;
	assign m_axis_tdata = (idx_q == 2'd0) ? run.u0 : (idx_q == 2'd1) ? run.u1 : run.u2;
	assign m_axis_tlast = (idx_q + 2'd1 == run.cnt);
	assign pop = !empty && (run.cnt == 2'd0 || (m_axis_tready && m_axis_tlast));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (pop)
			idx_q <= 2'd0;
		else if (m_axis_tvalid && m_axis_tready)
			idx_q <= idx_q + 2'd1;
	end

endmodule

FILE: sv/caption_latin_to_utf16_decoder_core.sv
// Top level of the Latin caption byte to UTF-16 decoder.
//  channel  | dir | payload
//  s_axis   | in  | tdata[7:0] data_byte, tlast block_end
//  m_axis   | out | tdata[15:0] code_unit, tlast last_of_run
//  cfg      | in  | cfg_index[1:0], cfg_data[15:0]
// A byte's run is queued when the byte is taken; its first code unit can leave the next cycle.
// The back end sends a run's code units in order and pops an empty run without sending any.
// Two queued runs absorb stalls; the input stalls only while both entries are held.
// Reset restores all decoder state and register defaults.
module caption_latin_to_utf16_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] code_unit
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cld_pkg::*;

	logic [1:0]  gl_q, gr_q;
	logic [15:0] lim_q;
	logic        full, empty, pop, fire;
	run_t        wrun, rrun;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !full;
	assign fire = s_axis_tvalid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gl_q <= 2'd0;
			gr_q <= 2'd1;
			lim_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GL: gl_q <= cfg_data[1:0];
				REG_GR: gr_q <= cfg_data[1:0];
				REG_LIMIT: lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cld_front u_front (
		.clk(clk), .arst_n(arst_n), .data_byte(s_axis_tdata), .block_end(s_axis_tlast),
		.in_fire(fire), .init_gl(gl_q), .init_gr(gr_q), .limit(lim_q), .run(wrun)
	);

	cld_queue #(.DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(fire), .wdata(wrun), .full(full),
		.pop(pop), .empty(empty), .rdata(rrun)
	);

	cld_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .run(rrun), .pop(pop),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

endmodule

FILE: sv/cld_checker.sv
// Port-level checker for the caption decoder, bound to the top level.
module cld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
		else $error("tlast changed under stall");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
		else $error("handshake signal unknown");
endmodule

bind caption_latin_to_utf16_decoder_core cld_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast), .cfg_ready(cfg_ready)
);

FILE: tb/tb_caption_latin_to_utf16_decoder_core.sv
// Self-checking testbench for the Latin caption to UTF-16 decoder core.
module tb_caption_latin_to_utf16_decoder_core;
	import cld_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] code_unit
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	caption_latin_to_utf16_decoder_core DUT (.*);

	typedef struct packed {
		logic [15:0] unit;
		logic        last;
	} unit_t;

	// Decoder mirror: registers and per-block state.
	gset_t       m_init_gl, m_init_gr;
	logic [15:0] m_limit;
	gset_t       m_sets [4];
	gset_t       m_gl, m_gr, m_saved;
	logic        m_shift, m_full;
	phase_t      m_phase;
	logic [7:0]  m_held;
	logic [15:0] m_count;
	logic [15:0] run_units [$];

	logic [8:0]  byte_queue [$];
	unit_t       expected_units [$];
	int          errors;
	int          send_idle_pct, recv_idle_pct;
	logic        recv_hold;
	int          hold_cycles;
	longint      cycle_count;
	logic        in_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic gset_t to_set(input logic [7:0] f);
		if (f == 8'h4A) return SET_ALNUM;
		if (f == 8'h4B) return SET_LATIN;
		if (f == 8'h4C) return SET_SPECIAL;
		return SET_LATIN;
	endfunction

	function automatic logic [15:0] latin_code(input logic [6:0] i);
		logic [15:0] tbl [96];
		tbl = '{16'h0000, 16'h00A1, 16'h00A2, 16'h00A3, 16'h20AC, 16'h00A5, 16'h0160,
			16'h00A7, 16'h0161, 16'h00A9, 16'h00AA, 16'h00AB, 16'h00AC, 16'h00AD,
			16'h00AE, 16'h00AF, 16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3, 16'h017D,
			16'h00B5, 16'h00B6, 16'h00B7, 16'h017E, 16'h00B9, 16'h00BA, 16'h00BB,
			16'h0152, 16'h0153, 16'h0178, 16'h00BF, 16'h00C0, 16'h00C1, 16'h00C2,
			16'h00C3, 16'h00C4, 16'h00C5, 16'h00C6, 16'h00C7, 16'h00C8, 16'h00C9,
			16'h00CA, 16'h00CB, 16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00D0,
			16'h00D1, 16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D6, 16'h00D7,
			16'h00D8, 16'h00D9, 16'h00DA, 16'h00DB, 16'h00DC, 16'h00DD, 16'h00DE,
			16'h00DF, 16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E4, 16'h00E5,
			16'h00E6, 16'h00E7, 16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB, 16'h00EC,
			16'h00ED, 16'h00EE, 16'h00EF, 16'h00F0, 16'h00F1, 16'h00F2, 16'h00F3,
			16'h00F4, 16'h00F5, 16'h00F6, 16'h00F7, 16'h00F8, 16'h00F9, 16'h00FA,
			16'h00FB, 16'h00FC, 16'h00FD, 16'h00FE, 16'h0000};
		if (i > 7'd95) return 16'h0000;
		return tbl[i];
	endfunction

	function automatic logic [15:0] special_code(input logic [7:0] b);
		logic [15:0] tbl [28];
		tbl = '{16'h00A4, 16'h00A6, 16'h00A8, 16'h00B4, 16'h00B8, 16'h00BC, 16'h00BD,
			16'h00BE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h2026, 16'h2588, 16'h2018, 16'h2019,
			16'h201C, 16'h201D, 16'h2022, 16'h2122, 16'h215B, 16'h215C, 16'h215D,
			16'h215E};
		if (b == 8'h21) return 16'h266A;
		if (b >= 8'h30 && b <= 8'h4B) return tbl[5'(b - 8'h30)];
		return 16'h0000;
	endfunction

	task automatic put_unit(input logic [15:0] u);
		if (m_count < m_limit && run_units.size() < 3) begin
			run_units.push_back(u);
			m_count++;
		end
	endtask

	task automatic start_block();
		m_sets = '{SET_ALNUM, SET_ALNUM, SET_LATIN, SET_SPECIAL};
		m_gl = m_init_gl;
		m_gr = m_init_gr;
		m_shift = 1'b0;
		m_saved = SET_ALNUM;
		m_phase = PH_IDLE;
		m_held = 8'h00;
		m_count = 16'd0;
		m_full = 1'b0;
	endtask

	task automatic print_gl(input logic [7:0] b);
		logic [15:0] u;
		if (b == 8'h20 || b == 8'h7F) put_unit({8'h00, b});
		else if (m_gl == SET_ALNUM) put_unit({8'h00, b});
		else if (m_gl == SET_LATIN) begin
			u = latin_code(7'(b - 8'h20));
			if (u != 0) put_unit(u);
		end else if (m_gl == SET_SPECIAL) begin
			u = special_code(b);
			if (u != 0) put_unit(u);
		end
		if (m_shift) begin
			m_gl = m_saved;
			m_shift = 1'b0;
		end
	endtask

	task automatic plain_byte(input logic [7:0] b);
		logic [15:0] u;
		if (b < 8'h20) begin
			case (b)
				8'h1B: m_phase = PH_ESC;
				8'h0F: m_gl = m_sets[0];
				8'h0E: m_gl = m_sets[1];
				8'h19, 8'h1D: begin
					m_saved = m_gl;
					m_gl = m_sets[(b == 8'h19) ? 2 : 3];
					m_shift = 1'b1;
				end
				8'h0D: begin
					put_unit(16'h000D);
					put_unit(16'h000A);
				end
				default: ;
			endcase
		end else if (b < 8'h80) print_gl(b);
		else if (b < 8'hA0) begin
			if (b == 8'h91) m_phase = PH_FLC;
			else if (b == 8'h9D) m_phase = PH_TIM1;
		end else if (m_gr == SET_ALNUM) put_unit({8'h00, b - 8'h80});
		else if (m_gr == SET_LATIN) begin
			u = latin_code(7'(b - 8'hA0));
			if (u != 0) put_unit(u);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [7:0] x;
		x = m_held;
		case (m_phase)
			PH_ESC: begin
				m_phase = PH_IDLE;
				if (b == 8'h6E) m_gl = m_sets[2];
				else if (b == 8'h6F) m_gl = m_sets[3];
				else if (b == 8'h7E) m_gr = m_sets[1];
				else if (b == 8'h7D) m_gr = m_sets[2];
				else if (b == 8'h7C) m_gr = m_sets[3];
				else if (b >= 8'h28 && b <= 8'h2B) begin
					m_held = b;
					m_phase = PH_DESIG;
				end else if (b == 8'h24) m_phase = PH_ESC24;
				else decode_byte(b);
			end
			PH_DESIG: begin
				if (b == 8'h20) m_phase = PH_FINAL;
				else begin
					m_sets[x[1:0]] = to_set(b);
					m_phase = PH_IDLE;
				end
			end
			PH_FINAL: begin
				m_sets[x[1:0]] = to_set(b);
				m_phase = PH_IDLE;
			end
			PH_ESC24: begin
				m_held = b;
				m_phase = PH_ESC24X;
			end
			PH_ESC24X: begin
				m_phase = PH_IDLE;
				if (b == 8'h20) begin
					if (x >= 8'h28 && x <= 8'h2B) m_phase = PH_FINAL;
					else begin
						decode_byte(x);
						decode_byte(8'h20);
					end
				end else if (x >= 8'h29 && x <= 8'h2B) m_sets[x[1:0]] = to_set(b);
				else begin
					m_sets[0] = to_set(x);
					decode_byte(b);
				end
			end
			PH_FLC: m_phase = PH_IDLE;
			PH_TIM1: m_phase = PH_TIM2;
			PH_TIM2: m_phase = PH_IDLE;
			default: begin
				m_phase = PH_IDLE;
				plain_byte(b);
			end
		endcase
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic blk_end);
		run_units.delete();
		if (!m_full) begin
			decode_byte(b);
			if (m_count >= m_limit) m_full = 1'b1;
		end
		foreach (run_units[k])
			expected_units.push_back('{run_units[k], k == run_units.size() - 1});
		if (blk_end) start_block();
	endtask

	// Driver: offers queued bytes and predicts each accepted transaction.
	always @(negedge clk) begin
		if (in_taken) begin
			predict_byte(s_axis_tdata, s_axis_tlast);
			void'(byte_queue.pop_front());
		end
		if (arst_n && byte_queue.size() > 0 &&
				(s_axis_tvalid && !in_taken ||
				$urandom_range(99) >= send_idle_pct)) begin
			s_axis_tvalid <= 1'b1;
			{s_axis_tlast, s_axis_tdata} <= byte_queue[0];
		end else begin
			s_axis_tvalid <= 1'b0;
			{s_axis_tlast, s_axis_tdata} <= 9'($urandom);
		end
		m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: checks every accepted code unit against the oldest expectation.
	always @(posedge clk) begin
		unit_t exp_u;
		cycle_count <= cycle_count + 1;
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_units.size() == 0) begin
				$display("%0t: unexpected code unit %h last %b", $time, m_axis_tdata,
					m_axis_tlast);
				errors <= errors + 1;
			end else begin
				exp_u = expected_units.pop_front();
				if (exp_u.unit !== m_axis_tdata || exp_u.last !== m_axis_tlast) begin
					$display("%0t: expected %h last %b, got %h last %b", $time, exp_u.unit,
						exp_u.last, m_axis_tdata, m_axis_tlast);
					errors <= errors + 1;
				end
			end
		end
		if (cycle_count > 64'd2000000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Long receiver hold-off, counted here while the sender keeps offering.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			recv_hold <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else recv_hold <= 1'b0;
	end

	task automatic wait_idle();
		while (byte_queue.size() > 0 || expected_units.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_GL) m_init_gl = gset_t'(val[1:0]);
		else if (idx == REG_GR) m_init_gr = gset_t'(val[1:0]);
		else m_limit = val;
	endtask

	task automatic add(input logic [7:0] b, input logic e = 1'b0);
		byte_queue.push_back({e, b});
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h1B;
			1: return 8'($urandom_range(8'h28, 8'h2B));
			2: return 8'($urandom_range(8'h4A, 8'h4D));
			3: return 8'h20;
			4: return 8'($urandom_range(8'h0C, 8'h1D));
			5: return 8'($urandom_range(8'h7C, 8'h7F));
			6: return 8'($urandom_range(8'h80, 8'h9F));
			7: return 8'h24;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				add(8'h1B);
				add(pick_byte());
				if ($urandom_range(1)) add(pick_byte());
			end
			add(pick_byte(), $urandom_range(11) == 0);
		end
		wait_idle();
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		hold_cycles = 0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GL;
		cfg_data = 16'h0000;
		m_init_gl = SET_ALNUM;
		m_init_gr = SET_LATIN;
		m_limit = 16'hFFFF;
		start_block();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, invocations, designations, shifts, operands, APR.
		add(8'h00); add(8'hFF); add(8'h20); add(8'h7F); add(8'h0D); add(8'hA0);
		add(8'h1B); add(8'h6F); add(8'h21); add(8'h30);
		add(8'h1B); add(8'h29); add(8'h20); add(8'h4C); add(8'h0E); add(8'h4B);
		add(8'h19); add(8'h41); add(8'h41); add(8'h91); add(8'h41);
		add(8'h9D); add(8'h41); add(8'h42); add(8'h1B, 1'b1);
		add(8'h1B); add(8'h24); add(8'h4C); add(8'h20);
		add(8'h1B); add(8'h24); add(8'h41); add(8'h20);
		add(8'h1B); add(8'h24); add(8'h28); add(8'h41, 1'b1);
		wait_idle();

		random_phase(28, 0, 0);
		// The receiver holds off while bytes keep coming in.
		hold_cycles = 300;
		random_phase(24, 0, 0);
		random_phase(28, 53, 0);
		write_reg(REG_GL, 16'd3);
		write_reg(REG_GR, 16'd0);
		write_reg(REG_LIMIT, 16'd1);
		random_phase(24, 0, 53);
		write_reg(REG_GL, 16'd2);
		write_reg(REG_GR, 16'd3);
		write_reg(REG_LIMIT, 16'd5);
		random_phase(24, 9, 9);
		write_reg(REG_GL, 16'd1);
		write_reg(REG_GR, 16'd2);
		write_reg(REG_LIMIT, 16'hFFFF);
		random_phase(24, 53, 53);

		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: filelist.f
sv/cld_pkg.sv
sv/cld_front.sv
sv/cld_queue.sv
sv/cld_back.sv
sv/caption_latin_to_utf16_decoder_core.sv
sv/cld_checker.sv
tb/tb_caption_latin_to_utf16_decoder_core.sv
